// ===== hdl/matrix_multiply_bias_core_macros.svh =====
// Assertion macros shared by the checker modules of the matrix multiply block.
// Depends on a clock named clk and a reset named rst in the module that uses them.
`ifndef MATRIX_MULTIPLY_BIAS_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_BIAS_CORE_MACROS_SVH

// Same-cycle implication, switched off while in reset
`define MMB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix_multiply_bias_core: assertion failed");

// Next-cycle implication, switched off while in reset
`define MMB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix_multiply_bias_core: assertion failed");

`endif

// ===== hdl/mmb_pkg.sv =====
// Shared types, constants and helpers of the matrix multiply with bias block.
// No dependencies; used by every module of the block but mmb_ram.
`timescale 1ns / 1ps
`default_nettype none

package mmb_pkg;

  // Store geometry
  localparam int MAX_DIM     = 16;
  localparam int DIM_HIGH    = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Field widths
  localparam int IDX_W   = 4;
  localparam int DIM_W   = 5;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 36;
  localparam int FRAC_SH = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd4;

  // Opcodes of an input beat
  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // load the accumulator with the bias
    logic valid;   // a store read was issued this cycle
    logic last;    // that read is the last of the inner dimension
  } mac_ctrl_t;

  // A dimension register is usable when in 1..DIM_HIGH
  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (int'(d) <= DIM_HIGH);
  endfunction

  // Q4.12 bias moved up to Q12.24 at accumulator width
  function automatic logic signed [ACC_W-1:0] bias_to_acc(input logic signed [ELEM_W-1:0] b);
    return {{(ACC_W-ELEM_W-FRAC_SH){b[ELEM_W-1]}}, b, {FRAC_SH{1'b0}}};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mmb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/mmb_mac.sv =====
// Shared multiply-accumulate unit: registered product, then 36-bit accumulator.
// Depends on mmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmb_mac (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mmb_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [mmb_pkg::ELEM_W-1:0]  bias,
  input  wire logic signed [mmb_pkg::ELEM_W-1:0]  a_data,
  input  wire logic signed [mmb_pkg::ELEM_W-1:0]  b_data,
  output logic signed      [mmb_pkg::ACC_W-1:0]   acc,
  output logic                                    done
);

  // Read-data stage flags, in step with the registered store read data
  logic rd_valid;
  logic rd_last;

  // Product stage
  logic signed [mmb_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;
  logic                              prod_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
    end else begin
      rd_valid   <= ctrl.valid;
      rd_last    <= ctrl.valid & ctrl.last;
      prod_valid <= rd_valid;
      prod_last  <= rd_last;
    end
  end

  // Multiply the two read words
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
  end

  // Accumulate; the sum wraps at 36 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      done <= 1'b0;
    end else begin
      done <= prod_valid & prod_last;
      if (ctrl.clear) begin
        acc <= mmb_pkg::bias_to_acc(bias);
      end else if (prod_valid) begin
        acc <= acc + mmb_pkg::ACC_W'(prod);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_bias_core.sv =====
// Matrix multiply with bias: top level with sequencer, A/B stores and output register.
// Depends on mmb_pkg, mmb_ram and mmb_mac.
//
// Input channel (in_valid / in_stall): one beat is a load of one A or B element
// (opcode, row_index, col_index, element_value) or a compute of one output row.
// Loads are written to their store and give no result. A compute gives b_cols result
// beats in column order, the last one flagged last_of_row, or a single beat with
// dim_error set when the dimensions are inconsistent or the row is out of range.
// Output channel (out_valid / out_stall): one result element per beat, Q12.24.
// Each result column is worked out by the single shared multiply-accumulate,
// walking the inner dimension through the store read port, the product
// register and the accumulator. An error beat goes from idle straight to the
// emit state, with no store reads.
// in_stall is high from a compute beat until its last result is in the output
// register. A stalled output register holds its beat and the sequencer waits.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written only while idle;
// the block does not enforce this. Reset (rst, synchronous) sets dimensions to 1,
// bias to 0 and empties the output register; stores hold undefined data until written.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_bias_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [mmb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mmb_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            opcode,
  input  wire logic [mmb_pkg::IDX_W-1:0]             row_index,
  input  wire logic [mmb_pkg::IDX_W-1:0]             col_index,
  input  wire logic signed [mmb_pkg::ELEM_W-1:0]     element_value,
  // output channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [mmb_pkg::ACC_W-1:0]           result_value,
  output logic [mmb_pkg::IDX_W-1:0]                  out_row,
  output logic [mmb_pkg::IDX_W-1:0]                  out_col,
  output logic                                       last_of_row,
  output logic                                       dim_error
);

  // Configuration registers
  logic [mmb_pkg::DIM_W-1:0]         a_rows;
  logic [mmb_pkg::DIM_W-1:0]         a_cols;
  logic [mmb_pkg::DIM_W-1:0]         b_rows;
  logic [mmb_pkg::DIM_W-1:0]         b_cols;
  logic signed [mmb_pkg::ELEM_W-1:0] bias_value;

  // Sequencer
  mmb_pkg::state_t           state;
  mmb_pkg::state_t           state_next;
  logic [mmb_pkg::IDX_W-1:0] row_reg;
  logic [mmb_pkg::IDX_W-1:0] col_cnt;
  logic [mmb_pkg::IDX_W-1:0] k_cnt;
  logic                      err_reg;

  logic in_acc;
  logic is_compute;
  logic bad_dims;
  logic k_last;
  logic col_last;
  logic out_free;
  logic out_load;
  logic load_in_range;

  // Stores and MAC
  logic                              a_we;
  logic                              b_we;
  logic [mmb_pkg::ADDR_W-1:0]        wr_addr;
  logic [mmb_pkg::ADDR_W-1:0]        a_raddr;
  logic [mmb_pkg::ADDR_W-1:0]        b_raddr;
  logic signed [mmb_pkg::ELEM_W-1:0] a_rdata;
  logic signed [mmb_pkg::ELEM_W-1:0] b_rdata;
  mmb_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [mmb_pkg::ACC_W-1:0]  mac_acc;
  logic                              mac_done;

  // Handshake and decode
  assign in_stall   = (state != mmb_pkg::ST_IDLE);
  assign in_acc     = in_valid & ~in_stall;
  assign is_compute = (opcode == mmb_pkg::OP_COMPUTE);
  assign out_free   = ~out_valid | ~out_stall;

  assign bad_dims = ~mmb_pkg::dim_ok(a_rows) | ~mmb_pkg::dim_ok(a_cols) |
                    ~mmb_pkg::dim_ok(b_rows) | ~mmb_pkg::dim_ok(b_cols) |
                    (b_rows != a_cols) |
                    ({1'b0, row_index} >= a_rows);

  assign k_last   = (({1'b0, k_cnt} + mmb_pkg::DIM_W'(1)) == a_cols);
  assign col_last = (({1'b0, col_cnt} + mmb_pkg::DIM_W'(1)) == b_cols);

  // Configuration writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows     <= mmb_pkg::DIM_W'(1);
      a_cols     <= mmb_pkg::DIM_W'(1);
      b_rows     <= mmb_pkg::DIM_W'(1);
      b_cols     <= mmb_pkg::DIM_W'(1);
      bias_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mmb_pkg::CFG_A_ROWS: a_rows     <= cfg_data[mmb_pkg::DIM_W-1:0];
        mmb_pkg::CFG_A_COLS: a_cols     <= cfg_data[mmb_pkg::DIM_W-1:0];
        mmb_pkg::CFG_B_ROWS: b_rows     <= cfg_data[mmb_pkg::DIM_W-1:0];
        mmb_pkg::CFG_B_COLS: b_cols     <= cfg_data[mmb_pkg::DIM_W-1:0];
        mmb_pkg::CFG_BIAS:   bias_value <= cfg_data[mmb_pkg::ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mmb_pkg::ST_IDLE: begin
        if (in_acc && is_compute) begin
          state_next = bad_dims ? mmb_pkg::ST_EMIT : mmb_pkg::ST_READ;
        end
      end
      mmb_pkg::ST_READ: begin
        if (k_last) begin
          state_next = mmb_pkg::ST_DRAIN;
        end
      end
      mmb_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_next = mmb_pkg::ST_EMIT;
        end
      end
      mmb_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (err_reg || col_last) ? mmb_pkg::ST_IDLE : mmb_pkg::ST_READ;
        end
      end
      default: state_next = mmb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mac_ctrl = '0;
    out_load = 1'b0;
    case (state)
      mmb_pkg::ST_IDLE: begin
        mac_ctrl.clear = in_acc & is_compute;
      end
      mmb_pkg::ST_READ: begin
        mac_ctrl.valid = 1'b1;
        mac_ctrl.last  = k_last;
      end
      mmb_pkg::ST_DRAIN: ;
      mmb_pkg::ST_EMIT: begin
        out_load       = out_free;
        mac_ctrl.clear = out_free & ~err_reg & ~col_last;
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mmb_pkg::ST_IDLE;
      row_reg <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
      err_reg <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        mmb_pkg::ST_IDLE: begin
          if (in_acc && is_compute) begin
            row_reg <= row_index;
            err_reg <= bad_dims;
            col_cnt <= '0;
            k_cnt   <= '0;
          end
        end
        mmb_pkg::ST_READ: begin
          k_cnt <= k_last ? '0 : k_cnt + mmb_pkg::IDX_W'(1);
        end
        mmb_pkg::ST_EMIT: begin
          if (out_free) begin
            col_cnt <= (err_reg || col_last) ? '0 : col_cnt + mmb_pkg::IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= err_reg ? '0 : mac_acc;
      out_row      <= row_reg;
      out_col      <= err_reg ? '0 : col_cnt;
      last_of_row  <= err_reg | col_last;
      dim_error    <= err_reg;
    end
  end

  // Store addressing: loads write in idle, compute reads row of A and column of B
  assign load_in_range = (int'(row_index) < mmb_pkg::MAX_DIM) &&
                         (int'(col_index) < mmb_pkg::MAX_DIM);
  assign a_we    = in_acc & (opcode == mmb_pkg::OP_WRITE_A) & load_in_range;
  assign b_we    = in_acc & (opcode == mmb_pkg::OP_WRITE_B) & load_in_range;
  assign wr_addr = mmb_pkg::ADDR_W'(int'(row_index) * mmb_pkg::MAX_DIM + int'(col_index));
  assign a_raddr = mmb_pkg::ADDR_W'(int'(row_reg) * mmb_pkg::MAX_DIM + int'(k_cnt));
  assign b_raddr = mmb_pkg::ADDR_W'(int'(k_cnt) * mmb_pkg::MAX_DIM + int'(col_cnt));

  mmb_ram #(
    .WIDTH (mmb_pkg::ELEM_W),
    .DEPTH (mmb_pkg::STORE_DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmb_ram #(
    .WIDTH (mmb_pkg::ELEM_W),
    .DEPTH (mmb_pkg::STORE_DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mmb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .bias   (bias_value),
    .a_data (a_rdata),
    .b_data (b_rdata),
    .acc    (mac_acc),
    .done   (mac_done)
  );

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_bias_core_checker.sv =====
// Port-level checker for the matrix multiply with bias block, bound to the top level.
// Depends on mmb_pkg and matrix_multiply_bias_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_bias_core_macros.svh"

module matrix_multiply_bias_core_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic [1:0]                            opcode,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic signed [mmb_pkg::ACC_W-1:0]      result_value,
  input wire logic [mmb_pkg::IDX_W-1:0]             out_col,
  input wire logic                                  last_of_row,
  input wire logic                                  dim_error
);

  // A stalled result beat stays put
  `MMB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value))

  // An error beat is a lone, zeroed, final beat
  `MMB_ASSERT_IMPL(a_err_beat, out_valid && dim_error, last_of_row && result_value == '0 && out_col == '0)

  // A compute beat makes the block busy
  `MMB_ASSERT_NEXT(a_busy_after_compute, in_valid && !in_stall && opcode == mmb_pkg::OP_COMPUTE, in_stall)

  // No new beat is taken in the middle of a row
  `MMB_ASSERT_IMPL(a_no_accept_mid_row, out_valid && !last_of_row, in_stall)

endmodule

bind matrix_multiply_bias_core matrix_multiply_bias_core_checker u_checker (.*);

`default_nettype wire

// ===== sim/matrix_multiply_bias_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_bias_core: A/B element loads, row computes, bad shapes.
// Every result beat is checked against an in-bench model of the Q12.24 row sums plus bias.
// Depends on mmb_pkg and the matrix_multiply_bias_core RTL only.

module matrix_multiply_bias_core_tb;

  localparam logic [1:0]                    OP_UNUSED     = 2'd3;
  localparam logic [mmb_pkg::CFG_IDX_W-1:0] CFG_NONE      = 3'd7;
  localparam int                            SETTLE_CYCLES = 24;
  localparam int                            CYCLE_LIMIT   = 1500000;
  localparam int                            ITEM_TARGET   = 410;
  localparam int                            TAIL_ITEMS    = 70;

  // One expected result beat
  typedef struct packed {
    logic [mmb_pkg::ACC_W-1:0] value;
    logic [mmb_pkg::IDX_W-1:0] row;
    logic [mmb_pkg::IDX_W-1:0] col;
    logic                      last;
    logic                      err;
  } row_result_t;

  logic                              clk           = 1'b0;
  logic                              rst           = 1'b1;
  logic                              cfg_we        = 1'b0;
  logic [mmb_pkg::CFG_IDX_W-1:0]     cfg_index     = '0;
  logic [mmb_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;
  logic                              in_valid      = 1'b0;
  logic                              in_stall;
  logic [1:0]                        opcode        = mmb_pkg::OP_WRITE_A;
  logic [mmb_pkg::IDX_W-1:0]         row_index     = '0;
  logic [mmb_pkg::IDX_W-1:0]         col_index     = '0;
  logic signed [mmb_pkg::ELEM_W-1:0] element_value = '0;
  logic                              out_valid;
  logic                              out_stall     = 1'b0;
  logic signed [mmb_pkg::ACC_W-1:0]  result_value;
  logic [mmb_pkg::IDX_W-1:0]         out_row;
  logic [mmb_pkg::IDX_W-1:0]         out_col;
  logic                              last_of_row;
  logic                              dim_error;

  // Shadow of the stores and registers
  logic signed [mmb_pkg::ELEM_W-1:0] a_mat [mmb_pkg::STORE_DEPTH];
  logic signed [mmb_pkg::ELEM_W-1:0] b_mat [mmb_pkg::STORE_DEPTH];
  bit                                a_known [mmb_pkg::STORE_DEPTH];
  bit                                b_known [mmb_pkg::STORE_DEPTH];
  logic [mmb_pkg::DIM_W-1:0]         rows_a   = 5'd1;
  logic [mmb_pkg::DIM_W-1:0]         cols_a   = 5'd1;
  logic [mmb_pkg::DIM_W-1:0]         rows_b   = 5'd1;
  logic [mmb_pkg::DIM_W-1:0]         cols_b   = 5'd1;
  logic signed [mmb_pkg::ELEM_W-1:0] bias_q12 = '0;

  row_result_t due_results [$];
  row_result_t head_result;
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          stim_beats  = 0;
  int          stall_left  = 0;
  bit          gap_en      = 1'b0;
  bit          stall_en    = 1'b0;

  matrix_multiply_bias_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .row_index    (row_index),
    .col_index    (col_index),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_row  (last_of_row),
    .dim_error    (dim_error)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Random helpers at the block's widths
  function automatic logic [mmb_pkg::IDX_W-1:0] rand_idx(input int hi);
    logic [31:0] w;
    w = $urandom_range(0, hi);
    return w[mmb_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [mmb_pkg::DIM_W-1:0] rand_dim(input int lo, input int hi);
    logic [31:0] w;
    w = $urandom_range(lo, hi);
    return w[mmb_pkg::DIM_W-1:0];
  endfunction

  function automatic logic [mmb_pkg::ELEM_W-1:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    return w[mmb_pkg::ELEM_W-1:0];
  endfunction

  // Elements lean towards the Q4.12 extremes now and then
  function automatic logic signed [mmb_pkg::ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return rand_word();
    endcase
  endfunction

  function automatic bit dim_fits(input logic [mmb_pkg::DIM_W-1:0] d);
    return (int'(d) >= 1) && (int'(d) <= mmb_pkg::DIM_HIGH);
  endfunction

  function automatic bit shape_ok();
    return dim_fits(rows_a) && dim_fits(cols_a) && dim_fits(rows_b) && dim_fits(cols_b) &&
           (rows_b == cols_a);
  endfunction

  // Expected beats of one compute: a single error beat, or b_cols sums in column order
  task automatic push_row_sums(input logic [mmb_pkg::IDX_W-1:0] row);
    row_result_t r;
    longint      sum;
    longint      av;
    longint      bv;
    longint      bq;
    int          j;
    int          k;
    if (!shape_ok() || int'(row) >= int'(rows_a)) begin
      r.value = '0;
      r.row   = row;
      r.col   = '0;
      r.last  = 1'b1;
      r.err   = 1'b1;
      due_results.push_back(r);
    end else begin
      bq = bias_q12;
      for (j = 0; j < int'(cols_b); j++) begin
        sum = bq * 4096;
        for (k = 0; k < int'(cols_a); k++) begin
          av = a_mat[int'(row) * mmb_pkg::MAX_DIM + k];
          bv = b_mat[k * mmb_pkg::MAX_DIM + j];
          sum += av * bv;
        end
        r.value = sum[mmb_pkg::ACC_W-1:0];
        r.row   = row;
        r.col   = j[mmb_pkg::IDX_W-1:0];
        r.last  = (j == int'(cols_b) - 1);
        r.err   = 1'b0;
        due_results.push_back(r);
      end
    end
  endtask

  // Model update for one accepted input beat
  task automatic track_beat(input logic [1:0] op, input logic [mmb_pkg::IDX_W-1:0] row,
                            input logic [mmb_pkg::IDX_W-1:0] col,
                            input logic signed [mmb_pkg::ELEM_W-1:0] val);
    int addr;
    addr = int'(row) * mmb_pkg::MAX_DIM + int'(col);
    case (op)
      mmb_pkg::OP_WRITE_A: begin
        a_mat[addr]   = val;
        a_known[addr] = 1'b1;
      end
      mmb_pkg::OP_WRITE_B: begin
        b_mat[addr]   = val;
        b_known[addr] = 1'b1;
      end
      mmb_pkg::OP_COMPUTE: push_row_sums(row);
      default: ;
    endcase
  endtask

  // Send one beat; valid is left high on return, the next call or wait_idle moves it
  task automatic send_beat(input logic [1:0] op, input logic [mmb_pkg::IDX_W-1:0] row,
                           input logic [mmb_pkg::IDX_W-1:0] col,
                           input logic signed [mmb_pkg::ELEM_W-1:0] val);
    int gap;
    if (gap_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    row_index     <= row;
    col_index     <= col;
    element_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_beat(op, row, col, val);
    stim_beats++;
  endtask

  // Drop valid and wait until every pending beat has come out and the core has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: one beat, with we low again before the task returns
  task automatic set_reg(input logic [mmb_pkg::CFG_IDX_W-1:0] idx,
                         input logic [mmb_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mmb_pkg::CFG_A_ROWS: rows_a   = data[mmb_pkg::DIM_W-1:0];
      mmb_pkg::CFG_A_COLS: cols_a   = data[mmb_pkg::DIM_W-1:0];
      mmb_pkg::CFG_B_ROWS: rows_b   = data[mmb_pkg::DIM_W-1:0];
      mmb_pkg::CFG_B_COLS: cols_b   = data[mmb_pkg::DIM_W-1:0];
      mmb_pkg::CFG_BIAS:   bias_q12 = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [mmb_pkg::DIM_W-1:0] ar,
                           input logic [mmb_pkg::DIM_W-1:0] ac,
                           input logic [mmb_pkg::DIM_W-1:0] br,
                           input logic [mmb_pkg::DIM_W-1:0] bc,
                           input logic [mmb_pkg::ELEM_W-1:0] bias);
    set_reg(mmb_pkg::CFG_A_ROWS, {{(mmb_pkg::CFG_DATA_W-mmb_pkg::DIM_W){1'b0}}, ar});
    set_reg(mmb_pkg::CFG_A_COLS, {{(mmb_pkg::CFG_DATA_W-mmb_pkg::DIM_W){1'b0}}, ac});
    set_reg(mmb_pkg::CFG_B_ROWS, {{(mmb_pkg::CFG_DATA_W-mmb_pkg::DIM_W){1'b0}}, br});
    set_reg(mmb_pkg::CFG_B_COLS, {{(mmb_pkg::CFG_DATA_W-mmb_pkg::DIM_W){1'b0}}, bc});
    set_reg(mmb_pkg::CFG_BIAS, bias);
  endtask

  // Load the operands a row needs; fresh rewrites the A row and some of B as well
  task automatic load_row_operands(input logic [mmb_pkg::IDX_W-1:0] row, input bit fresh);
    int j;
    int k;
    for (k = 0; k < int'(cols_a); k++)
      if (fresh || !a_known[int'(row) * mmb_pkg::MAX_DIM + k])
        send_beat(mmb_pkg::OP_WRITE_A, row, k[mmb_pkg::IDX_W-1:0], rand_elem());
    for (k = 0; k < int'(cols_a); k++)
      for (j = 0; j < int'(cols_b); j++)
        if ((fresh && $urandom_range(0, 3) == 0) || !b_known[k * mmb_pkg::MAX_DIM + j])
          send_beat(mmb_pkg::OP_WRITE_B, k[mmb_pkg::IDX_W-1:0], j[mmb_pkg::IDX_W-1:0],
                    rand_elem());
  endtask

  // Compute one row; a row that will really be computed gets its operands first
  task automatic run_row(input logic [mmb_pkg::IDX_W-1:0] row, input bit fresh);
    if (shape_ok() && int'(row) < int'(rows_a)) load_row_operands(row, fresh);
    send_beat(mmb_pkg::OP_COMPUTE, row, rand_idx(15), rand_word());
  endtask

  // Reset values: 1x1 matrices, zero bias, unused opcode ignored
  task automatic test_reset_state();
    send_beat(mmb_pkg::OP_WRITE_A, 4'd0, 4'd0, 16'sh7FFF);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd0, 4'd0, 16'sh8000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd15, 4'd0, 16'sh0000);
    send_beat(OP_UNUSED, 4'd15, 4'd15, 16'shFFFF);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd15, 16'shFFFF);
  endtask

  // Largest products, highest row and column, both bias extremes
  task automatic test_extremes();
    wait_idle();
    configure(5'd16, 5'd2, 5'd2, 5'd2, 16'h8000);
    send_beat(mmb_pkg::OP_WRITE_A, 4'd15, 4'd0, 16'sh8000);
    send_beat(mmb_pkg::OP_WRITE_A, 4'd15, 4'd1, 16'sh8000);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd0, 4'd0, 16'sh8000);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd1, 4'd0, 16'sh8000);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd0, 4'd1, 16'sh7FFF);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd1, 4'd1, 16'sh7FFF);
    send_beat(mmb_pkg::OP_WRITE_A, 4'd0, 4'd15, 16'sh7FFF);
    send_beat(mmb_pkg::OP_WRITE_B, 4'd15, 4'd15, 16'sh8000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd15, 4'd0, 16'sh0000);
    wait_idle();
    set_reg(mmb_pkg::CFG_BIAS, 16'h7FFF);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd15, 4'd0, 16'sh0000);
    send_beat(mmb_pkg::OP_WRITE_A, 4'd0, 4'd1, 16'sh0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
  endtask

  // Bad or inconsistent shapes give one error beat; an unknown register index is ignored
  task automatic test_bad_dims();
    wait_idle();
    configure(5'd2, 5'd3, 5'd2, 5'd2, 16'h0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    wait_idle();
    configure(5'd0, 5'd1, 5'd1, 5'd1, 16'h0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    wait_idle();
    configure(5'd1, 5'd1, 5'd1, 5'd17, 16'h0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
    wait_idle();
    configure(5'd2, 5'd31, 5'd31, 5'd1, 16'h0000);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd1, 4'd0, 16'sh0000);
    wait_idle();
    configure(5'd1, 5'd1, 5'd1, 5'd1, 16'h1234);
    set_reg(CFG_NONE, 16'hFFFF);
    send_beat(mmb_pkg::OP_COMPUTE, 4'd0, 4'd0, 16'sh0000);
  endtask

  // Longest inner dimension with the most negative A row, then the widest result row
  task automatic test_full_size();
    int k;
    wait_idle();
    configure(5'd16, 5'd16, 5'd16, 5'd1, 16'h7FFF);
    for (k = 0; k < mmb_pkg::MAX_DIM; k++)
      send_beat(mmb_pkg::OP_WRITE_A, 4'd15, k[mmb_pkg::IDX_W-1:0], 16'sh8000);
    run_row(4'd15, 1'b0);
    run_row(4'd0, 1'b1);
    wait_idle();
    configure(5'd16, 5'd1, 5'd1, 5'd16, 16'h8000);
    run_row(4'd15, 1'b0);
    run_row(rand_idx(15), 1'b1);
  endtask

  // Random phases, each a fresh setting followed by a mix of beats
  task automatic test_random(input int target);
    int                        start;
    int                        phase_goal;
    int                        choice;
    logic [mmb_pkg::DIM_W-1:0] ar;
    logic [mmb_pkg::DIM_W-1:0] ac;
    logic [mmb_pkg::DIM_W-1:0] br;
    logic [mmb_pkg::DIM_W-1:0] bc;
    start = stim_beats;
    while (stim_beats - start < target) begin
      wait_idle();
      gap_en   = ($urandom_range(0, 4) != 0);
      stall_en = ($urandom_range(0, 4) != 0);
      ar = rand_dim(1, 4);
      ac = rand_dim(1, 4);
      bc = rand_dim(1, 4);
      br = ac;
      case ($urandom_range(0, 9))
        0: begin
          // One long side at a time keeps the operand loads short
          ar = rand_dim(1, 16);
          if ($urandom_range(0, 1) != 0) begin
            ac = rand_dim(1, 16);
            bc = rand_dim(1, 2);
          end else begin
            ac = rand_dim(1, 2);
            bc = rand_dim(1, 16);
          end
          br = ac;
        end
        1: br = (ac == 5'd16) ? 5'd1 : ac + 5'd1;
        2: begin
          case ($urandom_range(0, 3))
            0:       ar = ($urandom_range(0, 1) != 0) ? 5'd0 : rand_dim(17, 31);
            1:       ac = ($urandom_range(0, 1) != 0) ? 5'd0 : rand_dim(17, 31);
            2:       br = ($urandom_range(0, 1) != 0) ? 5'd0 : rand_dim(17, 31);
            default: bc = ($urandom_range(0, 1) != 0) ? 5'd0 : rand_dim(17, 31);
          endcase
        end
        default: ;
      endcase
      configure(ar, ac, br, bc, rand_word());
      phase_goal = stim_beats + $urandom_range(15, 35);
      while (stim_beats < phase_goal) begin
        choice = $urandom_range(0, 19);
        if (choice < 11) begin
          if (shape_ok()) run_row(rand_idx(int'(rows_a) - 1), ($urandom_range(0, 1) != 0));
          else run_row(rand_idx(15), 1'b0);
        end else if (choice < 14) begin
          run_row(rand_idx(15), 1'b0);
        end else if (choice < 18) begin
          send_beat(($urandom_range(0, 1) != 0) ? mmb_pkg::OP_WRITE_B : mmb_pkg::OP_WRITE_A,
                    rand_idx(15), rand_idx(15), rand_elem());
        end else begin
          send_beat(OP_UNUSED, rand_idx(15), rand_idx(15), rand_word());
        end
      end
    end
  endtask

  // Closing stretch at full rate: no gaps, no stalls
  task automatic test_tail(input int target);
    int                        start;
    logic [mmb_pkg::DIM_W-1:0] ac;
    wait_idle();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    ac = rand_dim(1, 4);
    configure(rand_dim(1, 4), ac, ac, rand_dim(1, 4), rand_word());
    start = stim_beats;
    while (stim_beats - start < target)
      run_row(rand_idx(int'(rows_a) - 1), ($urandom_range(0, 1) != 0));
  endtask

  // Result side stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each result beat against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result beat at %0t: value %0d row %0d col %0d last %0b err %0b",
                   $time, result_value, out_row, out_col, last_of_row, dim_error);
        fail_count++;
      end else begin
        head_result = due_results.pop_front();
        if (result_value !== head_result.value || out_row !== head_result.row ||
            out_col !== head_result.col || last_of_row !== head_result.last ||
            dim_error !== head_result.err) begin
          if (fail_count < 10) begin
            $display("result mismatch at %0t: expected value %0d row %0d col %0d last %0b err %0b",
                     $time, $signed(head_result.value), head_result.row, head_result.col,
                     head_result.last, head_result.err);
            $display("  got value %0d row %0d col %0d last %0b err %0b",
                     result_value, out_row, out_col, last_of_row, dim_error);
          end
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("matrix_multiply_bias_core test failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gap_en   = 1'b1;
    stall_en = 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_bad_dims();
    test_full_size();
    test_random(ITEM_TARGET - TAIL_ITEMS - stim_beats);
    test_tail(TAIL_ITEMS);
    wait_idle();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("matrix_multiply_bias_core test passed");
    end else begin
      $display("matrix_multiply_bias_core test failed");
    end
    $finish;
  end

endmodule

// ===== matrix_multiply_bias_core.f =====
+incdir+hdl
hdl/mmb_pkg.sv
hdl/mmb_ram.sv
hdl/mmb_mac.sv
hdl/matrix_multiply_bias_core.sv
hdl/matrix_multiply_bias_core_checker.sv
sim/matrix_multiply_bias_core_tb.sv
